// ===== rtl/core/du128_pkg.sv =====
// Package for the 128-bit unsigned divider.
// Holds the operand and result transaction types, control structs and FSM states.
// No dependencies.
package du128_pkg;

    localparam int FIELD_W = 64;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend_high;
        logic [FIELD_W-1:0] dividend_low;
        logic [FIELD_W-1:0] divisor_high;
        logic [FIELD_W-1:0] divisor_low;
    } t_operands;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient_high;
        logic [FIELD_W-1:0] quotient_low;
        logic [FIELD_W-1:0] remainder_high;
        logic [FIELD_W-1:0] remainder_low;
        logic               divide_by_zero;
    } t_result;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic divisor_zero;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/divide_u128_with_remainder.sv =====
// Top level of the 128-bit unsigned divider with remainder.
// Depends on du128_pkg, du128_ctrl and du128_dp.
//
// Channel   Direction  Handshake                 Payload
// operands  in         start & !busy             i_operands (t_operands)
// result    out        o_done, one-cycle strobe  o_result   (t_result)
//
// A transaction runs from acceptance through the one-bit-per-cycle subtract loop
// (ST_RUN) to the o_done strobe (ST_DONE).
// A zero divisor skips the loop: the strobe follows in the cycle after acceptance.
// busy is low in the strobe cycle, so the next transaction may start there.
// Reset is synchronous and clears only the controller; the receiver cannot stall.
module divide_u128_with_remainder #(
    parameter int HALF_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  du128_pkg::t_operands i_operands,
    output logic                 o_done,
    output du128_pkg::t_result   o_result
);
    import du128_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    du128_ctrl #(
        .HALF_WIDTH(HALF_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_done   (o_done),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    du128_dp #(
        .HALF_WIDTH(HALF_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .i_operands (i_operands),
        .o_status   (dp_status),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/core/du128_dp.sv =====
// Datapath of the 128-bit unsigned divider: restoring shift-subtract, one bit per step.
// Depends on du128_pkg.
module du128_dp #(
    parameter int HALF_WIDTH = 64
) (
    input  logic                   i_clk,
    input  du128_pkg::t_dp_cmd     i_cmd,
    input  du128_pkg::t_operands   i_operands,
    output du128_pkg::t_dp_status  o_status,
    output du128_pkg::t_result     o_result
);
    import du128_pkg::*;

    localparam int W = 2 * HALF_WIDTH;

    logic [W-1:0] r_quo, n_quo;
    logic [W-1:0] r_rem, n_rem;
    logic [W-1:0] r_div, n_div;
    logic         r_dbz, n_dbz;

    logic [W-1:0] in_dividend;
    logic [W-1:0] in_divisor;
    logic [W-1:0] rem_shift;
    logic [W+1:0] diff;
    logic         geq;

    assign in_dividend = {i_operands.dividend_high[HALF_WIDTH-1:0],
                          i_operands.dividend_low[HALF_WIDTH-1:0]};
    assign in_divisor  = {i_operands.divisor_high[HALF_WIDTH-1:0],
                          i_operands.divisor_low[HALF_WIDTH-1:0]};

    assign o_status.divisor_zero = (in_divisor == '0);

    assign rem_shift = {r_rem[W-2:0], r_quo[W-1]};
    assign diff      = {1'b0, r_rem[W-1], rem_shift} - {2'b00, r_div};
    assign geq       = ~diff[W+1];

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_div = r_div;
        n_dbz = r_dbz;
        if (i_cmd.load) begin
            n_div = in_divisor;
            if (in_divisor == '0) begin
                n_quo = '1;
                n_rem = '1;
                n_dbz = 1'b1;
            end else begin
                n_quo = in_dividend;
                n_rem = '0;
                n_dbz = 1'b0;
            end
        end else if (i_cmd.step) begin
            n_rem = geq ? diff[W-1:0] : rem_shift;
            n_quo = {r_quo[W-2:0], geq};
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
        r_dbz <= n_dbz;
    end

    assign o_result.quotient_high  = FIELD_W'(r_quo[W-1:HALF_WIDTH]);
    assign o_result.quotient_low   = FIELD_W'(r_quo[HALF_WIDTH-1:0]);
    assign o_result.remainder_high = FIELD_W'(r_rem[W-1:HALF_WIDTH]);
    assign o_result.remainder_low  = FIELD_W'(r_rem[HALF_WIDTH-1:0]);
    assign o_result.divide_by_zero = r_dbz;

endmodule

// ===== rtl/core/du128_ctrl.sv =====
// Controller of the 128-bit unsigned divider: accepts a transaction, counts steps,
// strobes the result. Depends on du128_pkg.
module du128_ctrl #(
    parameter int HALF_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    output logic                   o_done,
    input  du128_pkg::t_dp_status  i_status,
    output du128_pkg::t_dp_cmd     o_cmd
);
    import du128_pkg::*;

    localparam int STEPS = 2 * HALF_WIDTH;
    localparam int CW    = $clog2(STEPS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          accept;
    logic          last_step;

    assign accept    = start && (r_state != ST_RUN);
    assign last_step = (r_cnt == CW'(STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_DONE: begin
                if (accept) begin
                    n_state = i_status.divisor_zero ? ST_DONE : ST_RUN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (last_step) begin
                    n_state = ST_DONE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = '0;
        end else if (r_state == ST_RUN) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    // outputs
    always_comb begin
        o_cmd.load = accept;
        o_cmd.step = 1'b0;
        busy       = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_cmd.step = 1'b1;
                busy       = 1'b1;
            end
            ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
